// ===== rtl/bcd_datetime_add_minutes_assert.svh =====
// Assertion macros for the BCD date/time adder RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef BCD_DATETIME_ADD_MINUTES_ASSERT_SVH
`define BCD_DATETIME_ADD_MINUTES_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BDAM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDAM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bdam_pkg.sv =====
// Package for the BCD date/time adder: payload structs, microcode format,
// microprogram, calendar constants and BCD conversion helpers. No dependencies.
package bdam_pkg;

   typedef struct packed {
      logic [7:0]  year_in;
      logic [4:0]  month_in;
      logic [5:0]  day_in;
      logic [5:0]  hour_in;
      logic [6:0]  minute_in;
      logic [15:0] add_minutes;
   } req_type;

   typedef struct packed {
      logic [7:0] year_out;
      logic [4:0] month_out;
      logic [5:0] day_out;
      logic [5:0] hour_out;
      logic [6:0] minute_out;
   } rsp_type;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_MUL,
      OP_QUO,
      OP_FIX,
      OP_MIN,
      OP_HOUR,
      OP_ROLL,
      OP_FIN
   } op_type;

   // Sequencing: next step, wait for request, wait for output slot, loop until fit
   typedef enum logic [1:0] {
      J_NEXT,
      J_REQ,
      J_OUT,
      J_NFIT
   } jmp_type;

   typedef enum logic {
      DIV_DAY,
      DIV_HOUR
   } dsel_type;

   localparam int PC_W = 4;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_IDLE = 4'd0;
   localparam pc_type PC_DMUL = 4'd1;
   localparam pc_type PC_DQUO = 4'd2;
   localparam pc_type PC_DFIX = 4'd3;
   localparam pc_type PC_HMUL = 4'd4;
   localparam pc_type PC_HQUO = 4'd5;
   localparam pc_type PC_HFIX = 4'd6;
   localparam pc_type PC_MIN  = 4'd7;
   localparam pc_type PC_HOUR = 4'd8;
   localparam pc_type PC_ROLL = 4'd9;
   localparam pc_type PC_FIN  = 4'd10;

   typedef struct packed {
      op_type   op;
      dsel_type dsel;
      jmp_type  jmp;
      pc_type   target;
   } uword_type;

   typedef struct packed {
      uword_type uw;
      logic      exec;
   } ctrl_type;

   typedef struct packed {
      logic fit;
      logic out_free;
   } stat_type;

   // Calendar constants
   localparam logic [10:0] MIN_PER_DAY   = 11'd1440;
   localparam logic [10:0] MIN_PER_HOUR  = 11'd60;
   localparam logic [7:0]  HOURS_PER_DAY = 8'd24;
   localparam logic [7:0]  LAST_YEAR     = 8'd99;
   localparam logic [7:0]  MONTHS        = 8'd12;
   localparam logic [4:0]  FEB_LEAP_LEN  = 5'd29;
   localparam logic [4:0]  GUARD_LIMIT   = 5'd16;

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   // Reciprocals slightly below 2^S/D; the estimate is low by at most one
   localparam logic [12:0] RECIP_DAY  = 13'd5825;
   localparam int          SHIFT_DAY  = 23;
   localparam logic [12:0] RECIP_HOUR = 13'd1092;
   localparam int          SHIFT_HOUR = 16;

   localparam int PROD_W = 29;

   function automatic logic [7:0] bcd2bin(input logic [7:0] b);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {4'b0, b[7:4]};
      lo = {4'b0, b[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

   // Tens by (v * 205) >> 11, exact for any 7-bit value
   function automatic logic [7:0] bin2bcd(input logic [6:0] v);
      logic [14:0] p;
      logic [3:0]  tens;
      logic [6:0]  ones;
      p    = {8'b0, v} * 15'd205;
      tens = p[14:11];
      ones = v - ({3'b0, tens} << 3) - ({3'b0, tens} << 1);
      return {tens, ones[3:0]};
   endfunction

   function automatic logic [4:0] days_in_month(input logic [7:0] year_bcd,
                                                input logic [4:0] month_bcd);
      logic [7:0] m;
      logic [7:0] y;
      logic [7:0] mi;
      m  = bcd2bin({3'b0, month_bcd});
      y  = bcd2bin(year_bcd);
      mi = m - 8'd1;
      if (m == 8'd0 || m > MONTHS) begin
         return 5'd0;
      end else if (m == 8'd2) begin
         return (y[1:0] == 2'b00) ? FEB_LEAP_LEN : MONTH_LEN[1];
      end else begin
         return MONTH_LEN[mi[3:0]];
      end
   endfunction

   // Microprogram
   function automatic uword_type ucode(input pc_type pc);
      uword_type w;
      w = '{op: OP_LOAD, dsel: DIV_DAY, jmp: J_REQ, target: PC_IDLE};
      case (pc)
         PC_IDLE: w = '{op: OP_LOAD, dsel: DIV_DAY,  jmp: J_REQ,  target: PC_IDLE};
         PC_DMUL: w = '{op: OP_MUL,  dsel: DIV_DAY,  jmp: J_NEXT, target: PC_IDLE};
         PC_DQUO: w = '{op: OP_QUO,  dsel: DIV_DAY,  jmp: J_NEXT, target: PC_IDLE};
         PC_DFIX: w = '{op: OP_FIX,  dsel: DIV_DAY,  jmp: J_NEXT, target: PC_IDLE};
         PC_HMUL: w = '{op: OP_MUL,  dsel: DIV_HOUR, jmp: J_NEXT, target: PC_IDLE};
         PC_HQUO: w = '{op: OP_QUO,  dsel: DIV_HOUR, jmp: J_NEXT, target: PC_IDLE};
         PC_HFIX: w = '{op: OP_FIX,  dsel: DIV_HOUR, jmp: J_NEXT, target: PC_IDLE};
         PC_MIN:  w = '{op: OP_MIN,  dsel: DIV_HOUR, jmp: J_NEXT, target: PC_IDLE};
         PC_HOUR: w = '{op: OP_HOUR, dsel: DIV_DAY,  jmp: J_NEXT, target: PC_IDLE};
         PC_ROLL: w = '{op: OP_ROLL, dsel: DIV_DAY,  jmp: J_NFIT, target: PC_FIN};
         PC_FIN:  w = '{op: OP_FIN,  dsel: DIV_DAY,  jmp: J_OUT,  target: PC_IDLE};
         default: w = '{op: OP_LOAD, dsel: DIV_DAY,  jmp: J_REQ,  target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/bdam_seq.sv =====
// Microcode sequencer for the BCD date/time adder: step counter, program
// table lookup and conditional jumps. Depends on bdam_pkg.
module bdam_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdam_pkg::stat_type stat,
   output bdam_pkg::ctrl_type ctrl
);
   import bdam_pkg::*;

   pc_type    pc_ff;
   pc_type    pc_in;
   uword_type uw;
   logic      exec;

   assign uw = ucode(pc_ff);

   always_comb begin
      pc_in = pc_ff;
      exec  = 1'b0;
      unique case (uw.jmp)
         J_NEXT: begin
            exec  = 1'b1;
            pc_in = pc_ff + 1'b1;
         end
         J_REQ: begin
            exec = req_valid;
            if (req_valid) pc_in = pc_ff + 1'b1;
         end
         J_OUT: begin
            exec = stat.out_free;
            if (stat.out_free) pc_in = uw.target;
         end
         J_NFIT: begin
            // step the month only while the day count does not fit
            exec = !stat.fit;
            if (stat.fit) pc_in = uw.target;
         end
         default: begin
            exec  = 1'b0;
            pc_in = PC_IDLE;
         end
      endcase
   end

   assign req_ready = (uw.jmp == J_REQ);
   assign ctrl      = '{uw: uw, exec: exec};

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/bdam_dp.sv =====
// Datapath of the BCD date/time adder: working registers, shared reciprocal
// multiplier, calendar roll logic and result register. Depends on bdam_pkg.
`include "bcd_datetime_add_minutes_assert.svh"

module bdam_dp (
   input  logic               clock,
   input  logic               reset,
   input  bdam_pkg::req_type  req_data,
   input  bdam_pkg::ctrl_type ctrl,
   output bdam_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bdam_pkg::rsp_type  rsp_data
);
   import bdam_pkg::*;

   logic [7:0]        yr_ff, yr_in;
   logic [4:0]        mon_ff, mon_in;
   logic [5:0]        dom_ff, dom_in;
   logic [5:0]        hr_ff, hr_in;
   logic [6:0]        mn_ff, mn_in;
   logic [15:0]       rem_ff, rem_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [5:0]        q_ff, q_in;
   logic [5:0]        dadd_ff, dadd_in;
   logic [4:0]        hadd_ff, hadd_in;
   logic [6:0]        dx_ff, dx_in;
   logic [4:0]        guard_ff, guard_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [12:0] k_sel;
   logic [10:0] div_sel;
   logic [5:0]  q_est;
   logic [16:0] qprod;
   logic        fix_hit;
   logic [5:0]  q_fix;
   logic [15:0] rem_fix;

   logic [7:0]  mn_sum;
   logic        mn_carry;
   logic [7:0]  mn_bin;
   logic [7:0]  mn_bcd;

   logic [7:0]  hr_sum;
   logic [7:0]  hr_bin;
   logic [6:0]  d_inc;
   logic [7:0]  hr_bcd;
   logic [7:0]  dom_bin;
   logic [6:0]  dx_sum;

   logic [4:0]  md;
   logic [7:0]  mon_next;
   logic [7:0]  mon_bcd;
   logic [7:0]  yr_next;
   logic [7:0]  yr_bcd;
   logic [7:0]  dx_bcd;

   // Division of the minute count by a day or an hour
   assign k_sel   = (ctrl.uw.dsel == DIV_DAY) ? RECIP_DAY : RECIP_HOUR;
   assign div_sel = (ctrl.uw.dsel == DIV_DAY) ? MIN_PER_DAY : MIN_PER_HOUR;
   assign q_est   = (ctrl.uw.dsel == DIV_DAY) ? prod_ff[SHIFT_DAY +: 6]
                                              : prod_ff[SHIFT_HOUR +: 6];
   assign qprod   = 17'(q_est) * 17'(div_sel);
   assign fix_hit = (rem_ff >= {5'b0, div_sel});
   assign q_fix   = fix_hit ? q_ff + 6'd1 : q_ff;
   assign rem_fix = fix_hit ? rem_ff - {5'b0, div_sel} : rem_ff;

   // Minute sum, one correction at most
   assign mn_sum   = bcd2bin({1'b0, mn_ff}) + {2'b0, rem_ff[5:0]};
   assign mn_carry = (mn_sum >= 8'(MIN_PER_HOUR));
   assign mn_bin   = mn_carry ? mn_sum - 8'(MIN_PER_HOUR) : mn_sum;
   assign mn_bcd   = bin2bcd(mn_bin[6:0]);

   // Hour sum stays below three days' worth of hours
   assign hr_sum = bcd2bin({2'b0, hr_ff}) + {3'b0, hadd_ff};
   always_comb begin
      if (hr_sum >= (HOURS_PER_DAY << 1)) begin
         hr_bin = hr_sum - (HOURS_PER_DAY << 1);
         d_inc  = 7'd2;
      end else if (hr_sum >= HOURS_PER_DAY) begin
         hr_bin = hr_sum - HOURS_PER_DAY;
         d_inc  = 7'd1;
      end else begin
         hr_bin = hr_sum;
         d_inc  = 7'd0;
      end
   end
   assign hr_bcd  = bin2bcd(hr_bin[6:0]);
   assign dom_bin = bcd2bin({2'b0, dom_ff});
   assign dx_sum  = dom_bin[6:0] + {1'b0, dadd_ff} + d_inc;

   // Month roll
   assign md       = days_in_month(yr_ff, mon_ff);
   assign mon_next = bcd2bin({3'b0, mon_ff}) + 8'd1;
   assign mon_bcd  = bin2bcd(mon_next[6:0]);
   always_comb begin
      yr_next = bcd2bin(yr_ff) + 8'd1;
      if (yr_next > LAST_YEAR) yr_next = 8'd0;
   end
   assign yr_bcd = bin2bcd(yr_next[6:0]);
   assign dx_bcd = bin2bcd(dx_ff);

   assign stat.fit      = (dx_ff <= {2'b0, md}) || (guard_ff == GUARD_LIMIT);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      yr_in        = yr_ff;
      mon_in       = mon_ff;
      dom_in       = dom_ff;
      hr_in        = hr_ff;
      mn_in        = mn_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      q_in         = q_ff;
      dadd_in      = dadd_ff;
      hadd_in      = hadd_ff;
      dx_in        = dx_ff;
      guard_in     = guard_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctrl.exec) begin
         unique case (ctrl.uw.op)
            OP_LOAD: begin
               yr_in    = req_data.year_in;
               mon_in   = req_data.month_in;
               dom_in   = req_data.day_in;
               hr_in    = req_data.hour_in;
               mn_in    = req_data.minute_in;
               rem_in   = req_data.add_minutes;
               guard_in = 5'd0;
            end
            OP_MUL: begin
               prod_in = PROD_W'(rem_ff) * PROD_W'(k_sel);
            end
            OP_QUO: begin
               q_in   = q_est;
               rem_in = rem_ff - qprod[15:0];
            end
            OP_FIX: begin
               rem_in = rem_fix;
               if (ctrl.uw.dsel == DIV_DAY) begin
                  dadd_in = q_fix;
               end else begin
                  hadd_in = q_fix[4:0];
               end
            end
            OP_MIN: begin
               mn_in = mn_bcd[6:0];
               if (mn_carry) hadd_in = hadd_ff + 5'd1;
            end
            OP_HOUR: begin
               hr_in = hr_bcd[5:0];
               dx_in = dx_sum;
            end
            OP_ROLL: begin
               dx_in    = dx_ff - {2'b0, md};
               guard_in = guard_ff + 5'd1;
               if (mon_next <= MONTHS) begin
                  mon_in = mon_bcd[4:0];
               end else begin
                  mon_in = 5'd1;
                  yr_in  = yr_bcd;
               end
            end
            OP_FIN: begin
               rsp_in.year_out   = yr_ff;
               rsp_in.month_out  = mon_ff;
               rsp_in.day_out    = dx_bcd[5:0];
               rsp_in.hour_out   = hr_ff;
               rsp_in.minute_out = mn_ff;
               rsp_valid_in      = 1'b1;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_ready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      yr_ff    <= yr_in;
      mon_ff   <= mon_in;
      dom_ff   <= dom_in;
      hr_ff    <= hr_in;
      mn_ff    <= mn_in;
      rem_ff   <= rem_in;
      prod_ff  <= prod_in;
      q_ff     <= q_in;
      dadd_ff  <= dadd_in;
      hadd_ff  <= hadd_in;
      dx_ff    <= dx_in;
      guard_ff <= guard_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BDAM_ASSERT_NXT(a_fin_loads, clock, reset, ctrl.exec && ctrl.uw.op == OP_FIN, rsp_valid_ff, "result register not loaded")
   `BDAM_ASSERT_NXT(a_hour_rem, clock, reset, ctrl.exec && ctrl.uw.op == OP_FIX && ctrl.uw.dsel == DIV_HOUR, rem_ff < 16'(MIN_PER_HOUR), "minute remainder not reduced")
   `BDAM_ASSERT_IMP(a_hadd_range, clock, reset, ctrl.exec && ctrl.uw.op == OP_HOUR, hadd_ff <= 5'd24, "hour addend out of range")
   `BDAM_ASSERT_IMP(a_roll_guard, clock, reset, ctrl.exec && ctrl.uw.op == OP_ROLL, guard_ff < GUARD_LIMIT, "month roll ran past its guard")

endmodule

// ===== rtl/bcd_datetime_add_minutes.sv =====
// BCD date/time adder, top level: microcode sequencer and datapath.
// Depends on bdam_pkg, bdam_seq and bdam_dp.
//
// Usage: present a packed-BCD date/time and a binary minute count on req_data
// with req_valid; the transaction completes when req_ready is also high. One
// result transaction follows on rsp_data/rsp_valid and completes when
// rsp_ready is high.
// Operation: a short microprogram runs each transaction. It splits the minute
// count with a shared reciprocal multiplier (three steps per divisor), adds
// minutes and hours, then steps one month per cycle while the day count
// exceeds the month length. With k month steps (0 to 16, normally at most
// five), the final step loads the output register and the sequencer returns
// to its idle step, where it takes the next request.
// The result sits in an output register, so the next request is taken while
// an earlier result waits. If the receiver stalls, the sequencer holds at its
// final step until the register frees up.
// Reset (synchronous, active high) returns the sequencer to its idle step and
// empties the output register.
module bcd_datetime_add_minutes (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bdam_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bdam_pkg::rsp_type rsp_data
);
   import bdam_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   bdam_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   bdam_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
